// ===== design/lctw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lctw_pkg;

   localparam int ADC_W        = 24;
   localparam int CALW_W       = 16;
   localparam int DB_W         = 16;
   localparam int MAXW_W       = 23;
   localparam int CENTI_W      = 7;
   localparam int PROD1_W      = ADC_W + CALW_W;
   localparam int PROD_W       = PROD1_W + CENTI_W;
   localparam int DIVD_W       = PROD_W;
   localparam int DIVS_W       = ADC_W;
   localparam int DIV_CNT_W    = $clog2(DIVD_W + 1);
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = ADC_W;
   localparam int RSP_FIELDS_W = MAXW_W + ADC_W + 2;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int SAMPLES_PER_BATCH_DEF = 8;

   localparam logic [ADC_W-1:0]   SIGN_FLIP       = 24'h800000;
   localparam logic [CENTI_W-1:0] CENTI_PER_GRAM  = 7'd100;
   localparam logic [ADC_W-1:0]   CAL_RAW_RST     = 24'd8493860;
   localparam logic [CALW_W-1:0]  CAL_WEIGHT_RST  = 16'd100;
   localparam logic [DB_W-1:0]    DEADBAND_RST    = 16'd20;
   localparam logic [MAXW_W-1:0]  MAX_WEIGHT_RST  = 23'd500000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_CAL_RAW    = 2'd0,
      REG_CAL_WEIGHT = 2'd1,
      REG_DEADBAND   = 2'd2,
      REG_MAX_WEIGHT = 2'd3
   } csr_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MEAN_WAIT,
      ST_CHECK,
      ST_MUL_B,
      ST_WDIV,
      ST_WDIV_WAIT,
      ST_DONE
   } lctw_state_type;

   typedef struct packed {
      logic        take;
      logic        mean_start;
      logic        div_start;
      logic        set_tare;
      logic        set_trim;
      logic        set_cal_err;
      logic        mul_a;
      logic        mul_b;
      logic        set_weight;
      logic        finish;
   } lctw_cmd_type;

   typedef struct packed {
      logic full;
      logic count_last;
      logic rsp_pending;
      logic div_busy;
      logic div_done;
      logic batch_weigh;
      logic trim_above;
      logic cal_above;
   } lctw_status_type;

endpackage
`default_nettype wire

// ===== design/lctw_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lctw_div
   import lctw_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIVD_W-1:0] dividend,
   input  wire logic [DIVS_W-1:0] divisor,
   output logic                   busy,
   output logic                   done,
   output logic [DIVD_W-1:0]      quotient
);

   logic [DIVS_W-1:0]    rem_ff, rem_in;
   logic [DIVD_W-1:0]    quo_ff, quo_in;
   logic [DIVS_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVS_W:0]      trial;
   logic [DIVS_W:0]      trial_sub;
   logic                 trial_ge;

   assign trial     = {rem_ff, quo_ff[DIVD_W-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = trial_ge ? trial_sub[DIVS_W-1:0] : trial[DIVS_W-1:0];
         quo_in = {quo_ff[DIVD_W-2:0], trial_ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== design/lctw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lctw_ctrl
   import lctw_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire lctw_status_type status,
   output lctw_cmd_type         cmd
);

   lctw_state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE) && !status.full
                       && !(status.rsp_pending && status.count_last);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.take    = req_tvalid && req_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (status.full) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean_start = 1'b1;
            state_in       = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.batch_weigh) begin
               cmd.set_trim = 1'b1;
               state_in     = ST_CHECK;
            end else begin
               cmd.set_tare = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_CHECK: begin
            priority if (!status.trim_above) begin
               state_in = ST_DONE;
            end else if (!status.cal_above) begin
               cmd.set_cal_err = 1'b1;
               state_in        = ST_DONE;
            end else begin
               cmd.mul_a = 1'b1;
               state_in  = ST_MUL_B;
            end
         end
         ST_MUL_B: begin
            cmd.mul_b = 1'b1;
            state_in  = ST_WDIV;
         end
         ST_WDIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WDIV_WAIT;
         end
         ST_WDIV_WAIT: begin
            if (status.div_done) begin
               cmd.set_weight = 1'b1;
               state_in       = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/lctw_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lctw_dp
   import lctw_pkg::*;
#(
   parameter int SAMPLES_PER_BATCH = SAMPLES_PER_BATCH_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lctw_cmd_type          cmd,
   input  wire logic [ADC_W-1:0]      req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic [ADC_W-1:0]      cal_raw,
   input  wire logic [CALW_W-1:0]     cal_weight,
   input  wire logic [DB_W-1:0]       deadband,
   input  wire logic [MAXW_W-1:0]     max_weight,
   input  wire logic                  rsp_tready,
   output lctw_status_type            status,
   output logic                       rsp_tvalid,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser
);

   localparam int CNT_W    = $clog2(SAMPLES_PER_BATCH + 1);
   localparam int SUM_W    = ADC_W + $clog2(SAMPLES_PER_BATCH);
   localparam int TRIM_DIV = SAMPLES_PER_BATCH - 2;
   localparam int RECIP_W  = SUM_W + 1;
   localparam int QPROD_W  = SUM_W + RECIP_W;
   localparam int MEAN_SH  = SUM_W + $clog2(SAMPLES_PER_BATCH);
   localparam int TRIM_SH  = SUM_W + $clog2(TRIM_DIV);
   // ceil(2^sh / n): exact floor division for any dividend below 2^SUM_W
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << MEAN_SH) + 64'(SAMPLES_PER_BATCH - 1)) / 64'(SAMPLES_PER_BATCH));
   localparam logic [RECIP_W-1:0] TRIM_RECIP =
      RECIP_W'(((64'd1 << TRIM_SH) + 64'(TRIM_DIV - 1)) / 64'(TRIM_DIV));

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               kind_ff, kind_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [ADC_W-1:0]   max_ff, max_in;
   logic [ADC_W-1:0]   min_ff, min_in;
   logic [ADC_W-1:0]   tare_ff, tare_in;
   logic               cal_err_ff, cal_err_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [ADC_W-1:0]   trim_ff, trim_in;
   logic [QPROD_W-1:0] qprod_ff, qprod_in;
   logic [PROD1_W-1:0] prod1_ff, prod1_in;
   logic [PROD_W-1:0]  prod2_ff, prod2_in;
   logic [MAXW_W-1:0]  weight_ff, weight_in;
   logic               sat_ff, sat_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [MAXW_W-1:0]  rsp_weight_ff, rsp_weight_in;
   logic [ADC_W-1:0]   rsp_tare_ff, rsp_tare_in;
   logic               rsp_err_ff, rsp_err_in;
   logic               rsp_sat_ff, rsp_sat_in;

   logic [ADC_W-1:0]   code;
   logic               restart;
   logic [CNT_W-1:0]   base_count;
   logic [SUM_W-1:0]   base_sum;
   logic [ADC_W-1:0]   base_max;
   logic [ADC_W-1:0]   base_min;
   logic [SUM_W-1:0]   trim_sum;
   logic [SUM_W-1:0]   mean_src;
   logic [RECIP_W-1:0] mean_recip;
   logic [ADC_W-1:0]   mean_quo;
   logic [ADC_W-1:0]   diff;
   logic [ADC_W-1:0]   cdiff;

   logic [DIVD_W-1:0]  div_dividend;
   logic [DIVS_W-1:0]  div_divisor;
   logic               div_busy;
   logic               div_done;
   logic [DIVD_W-1:0]  div_quo;

   assign code       = req_tdata ^ SIGN_FLIP;
   assign restart    = (count_ff != '0) && (req_tuser != kind_ff);
   assign base_count = restart ? '0 : count_ff;
   assign base_sum   = restart ? '0 : sum_ff;
   assign base_max   = restart ? '0 : max_ff;
   assign base_min   = restart ? '1 : min_ff;
   assign trim_sum   = sum_ff - SUM_W'(max_ff) - SUM_W'(min_ff);
   assign mean_src   = kind_ff ? trim_sum : sum_ff;
   assign mean_recip = kind_ff ? TRIM_RECIP : MEAN_RECIP;
   assign mean_quo   = kind_ff ? qprod_ff[TRIM_SH +: ADC_W] : qprod_ff[MEAN_SH +: ADC_W];
   assign diff       = trim_ff - tare_ff;
   assign cdiff      = cal_raw - tare_ff;

   assign div_dividend = prod2_ff;
   assign div_divisor  = cdiff;

   lctw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      count_in   = count_ff;
      kind_in    = kind_ff;
      sum_in     = sum_ff;
      max_in     = max_ff;
      min_in     = min_ff;
      tare_in    = tare_ff;
      cal_err_in = cal_err_ff;
      trim_in    = trim_ff;
      qprod_in   = qprod_ff;
      prod1_in   = prod1_ff;
      prod2_in   = prod2_ff;
      weight_in  = weight_ff;
      sat_in     = sat_ff;

      if (cmd.take) begin
         count_in = base_count + 1'b1;
         kind_in  = req_tuser;
         sum_in   = base_sum + SUM_W'(code);
         max_in   = (code > base_max) ? code : base_max;
         min_in   = (code < base_min) ? code : base_min;
      end
      if (cmd.mean_start) begin
         qprod_in  = QPROD_W'(mean_src) * QPROD_W'(mean_recip);
         weight_in = '0;
         sat_in    = 1'b0;
      end
      if (cmd.set_tare) begin
         tare_in = mean_quo;
      end
      if (cmd.set_trim) begin
         trim_in = mean_quo;
      end
      if (cmd.set_cal_err) begin
         cal_err_in = 1'b1;
      end
      if (cmd.mul_a) begin
         prod1_in = PROD1_W'(diff) * PROD1_W'(cal_weight);
      end
      if (cmd.mul_b) begin
         prod2_in = PROD_W'(prod1_ff) * PROD_W'(CENTI_PER_GRAM);
      end
      if (cmd.set_weight) begin
         cal_err_in = 1'b0;
         priority if (div_quo < DIVD_W'(deadband)) begin
            weight_in = '0;
            sat_in    = 1'b0;
         end else if (div_quo > DIVD_W'(max_weight)) begin
            weight_in = max_weight;
            sat_in    = 1'b1;
         end else begin
            weight_in = div_quo[MAXW_W-1:0];
            sat_in    = 1'b0;
         end
      end
      if (cmd.finish) begin
         count_in = '0;
         sum_in   = '0;
         max_in   = '0;
         min_in   = '1;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_weight_in = rsp_weight_ff;
      rsp_tare_in   = rsp_tare_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_sat_in    = rsp_sat_ff;
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         rsp_kind_in   = kind_ff;
         rsp_weight_in = weight_ff;
         rsp_tare_in   = tare_ff;
         rsp_err_in    = cal_err_ff;
         rsp_sat_in    = sat_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         kind_ff      <= 1'b0;
         sum_ff       <= '0;
         max_ff       <= '0;
         min_ff       <= '1;
         tare_ff      <= '0;
         cal_err_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         kind_ff      <= kind_in;
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         tare_ff      <= tare_in;
         cal_err_ff   <= cal_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      trim_ff       <= trim_in;
      qprod_ff      <= qprod_in;
      prod1_ff      <= prod1_in;
      prod2_ff      <= prod2_in;
      weight_ff     <= weight_in;
      sat_ff        <= sat_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_weight_ff <= rsp_weight_in;
      rsp_tare_ff   <= rsp_tare_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   assign status.full        = (count_ff == CNT_W'(SAMPLES_PER_BATCH));
   assign status.count_last  = (count_ff == CNT_W'(SAMPLES_PER_BATCH - 1));
   assign status.rsp_pending = rsp_valid_ff;
   assign status.div_busy    = div_busy;
   assign status.div_done    = div_done;
   assign status.batch_weigh = kind_ff;
   assign status.trim_above  = (trim_ff > tare_ff);
   assign status.cal_above   = (cal_raw > tare_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0), rsp_sat_ff, rsp_err_ff,
                        rsp_tare_ff, rsp_weight_ff};

endmodule
`default_nettype wire

// ===== design/load_cell_trimmed_weigher.sv =====
// Sequence: after a batch's last sample the FSM passes ST_MEAN and ST_MEAN_WAIT; a tare batch
// then goes to ST_DONE, a weigh batch to ST_CHECK and then ST_DONE or, if it runs the 47-step
// restoring divider, via ST_MUL_B, ST_WDIV and ST_WDIV_WAIT. ST_DONE raises rsp_tvalid.
// Throughput: one sample per cycle inside a batch; the batch-ending sample holds off input
// until the FSM is back in ST_IDLE; a last sample also waits while a result is unaccepted.
// Reset (synchronous, active high) restores register defaults, clears tare, flag, batch, result.
`timescale 1ns / 1ps
`default_nettype none
module load_cell_trimmed_weigher
   import lctw_pkg::*;
#(
   parameter int SAMPLES_PER_BATCH = SAMPLES_PER_BATCH_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ADC_W-1:0]      req_tdata,  // adc_code
   input  wire logic                  req_tuser,  // req_type
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // weight_centigrams[22:0], tare_value[46:23], cal_error[47], saturated[48], zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,  // result_kind
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [ADC_W-1:0]  cal_raw_ff, cal_raw_in;
   logic [CALW_W-1:0] cal_weight_ff, cal_weight_in;
   logic [DB_W-1:0]   deadband_ff, deadband_in;
   logic [MAXW_W-1:0] max_weight_ff, max_weight_in;

   lctw_cmd_type    cmd;
   lctw_status_type status;

   always_comb begin
      cal_raw_in    = cal_raw_ff;
      cal_weight_in = cal_weight_ff;
      deadband_in   = deadband_ff;
      max_weight_in = max_weight_ff;
      if (csr_we) begin
         unique case (csr_reg_type'(csr_addr))
            REG_CAL_RAW:    cal_raw_in    = csr_wdata[ADC_W-1:0];
            REG_CAL_WEIGHT: cal_weight_in = csr_wdata[CALW_W-1:0];
            REG_DEADBAND:   deadband_in   = csr_wdata[DB_W-1:0];
            REG_MAX_WEIGHT: max_weight_in = csr_wdata[MAXW_W-1:0];
            default:        cal_raw_in    = cal_raw_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_raw_ff    <= CAL_RAW_RST;
         cal_weight_ff <= CAL_WEIGHT_RST;
         deadband_ff   <= DEADBAND_RST;
         max_weight_ff <= MAX_WEIGHT_RST;
      end else begin
         cal_raw_ff    <= cal_raw_in;
         cal_weight_ff <= cal_weight_in;
         deadband_ff   <= deadband_in;
         max_weight_ff <= max_weight_in;
      end
   end

   lctw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lctw_dp #(
      .SAMPLES_PER_BATCH (SAMPLES_PER_BATCH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cal_raw    (cal_raw_ff),
      .cal_weight (cal_weight_ff),
      .deadband   (deadband_ff),
      .max_weight (max_weight_ff),
      .rsp_tready (rsp_tready),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   a_no_take_while_dividing: assert property (@(posedge clock) disable iff (reset)
      status.div_busy |-> !req_tready)
      else $error("input accepted while divider busy");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_tvalid)
      else $error("pending result overwritten");

   a_divider_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");
`endif

endmodule
`default_nettype wire
